>>> rtl/dtsg_pkg.sv
// Shared types and constants for the debounced toggle switch groups block.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package dtsg_pkg;

    localparam int LINE_BITS = 9;
    localparam int DEB_W     = 7;
    localparam int CHAN_W    = 4;
    localparam int KEY_W     = 7;
    localparam int HOLD_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    localparam logic [KEY_W-1:0] KEY_STRIDE_SH = 7'd3;
    localparam logic [KEY_W-1:0] KEY_BASE      = 7'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL  = 1'b1;

    localparam logic [DEB_W-1:0]  DEB_RESET  = 7'd10;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 4'd0;

    typedef logic [LINE_BITS-1:0]     levels_t;
    typedef logic [CHAN_W-1:0]        chan_t;
    typedef logic [KEY_W-1:0]         key_t;
    typedef logic signed [HOLD_W-1:0] hold_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_CLR,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic start;
        logic rd;
        logic upd;
        logic tog;
        logic adv;
        logic clr_k;
        logic k_inc;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic press;
        logic is_on;
        logic idx_last;
        logic k_last;
        logic k_hit;
        logic can_emit;
        logic pend_valid;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/dtsg_in_if.sv
// Input channel: one scan tick of raw switch levels per beat.
// Depends on dtsg_pkg.
`default_nettype none

interface dtsg_in_if;
    logic             valid;
    logic             ready;
    dtsg_pkg::levels_t switch_levels;

    modport source (output valid, output switch_levels, input ready);
    modport sink   (input valid, input switch_levels, output ready);
endinterface

`default_nettype wire

>>> rtl/dtsg_out_if.sv
// Output channel: one note event per beat.
// Depends on dtsg_pkg.
`default_nettype none

interface dtsg_out_if;
    logic              valid;
    logic              ready;
    dtsg_pkg::chan_t   channel;
    dtsg_pkg::key_t    key_number;
    logic              note_on;
    dtsg_pkg::levels_t lit_vector;
    logic              last_event;

    modport source (output valid, output channel, output key_number, output note_on,
                    output lit_vector, output last_event, input ready);
    modport sink   (input valid, input channel, input key_number, input note_on,
                    input lit_vector, input last_event, output ready);
endinterface

`default_nettype wire

>>> rtl/dtsg_dp.sv
// Datapath: configuration, latches, hold-off memory, scan counters,
// pending event and output register. Depends on dtsg_pkg and dtsg_out_if.
`default_nettype none

module dtsg_dp #(
    parameter int GROUPS = 3,
    parameter int SHIFTS = 3
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [dtsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dtsg_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  wire dtsg_pkg::levels_t                  levels,
    input  wire dtsg_pkg::cmd_t                     cmd,
    output dtsg_pkg::sts_t                          sts,
    dtsg_out_if.source                              ev
);
    import dtsg_pkg::*;

    localparam int NSW = GROUPS * SHIFTS;
    localparam int IW  = (NSW > 1) ? $clog2(NSW) : 1;
    localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SW  = (SHIFTS > 1) ? $clog2(SHIFTS) : 1;

    logic [DEB_W-1:0] deb_reg;
    chan_t            chan_reg;
    levels_t          levels_reg;

    logic [NSW-1:0] lat_reg, lat_next;
    logic [NSW-1:0] hv_reg;
    hold_t          mem [NSW];
    hold_t          rd_data_reg;
    logic           rd_valid_reg;

    logic [IW-1:0] idx_reg, base_reg;
    logic [GW-1:0] g_reg;
    logic [SW-1:0] s_reg, k_reg;
    logic [IW-1:0] gk;

    logic          pend_valid_reg;
    chan_t         pend_chan_reg;
    key_t          pend_key_reg;
    logic          pend_on_reg;
    levels_t       pend_lit_reg;

    logic          out_valid_reg;
    chan_t         out_chan_reg;
    key_t          out_key_reg;
    logic          out_on_reg;
    levels_t       out_lit_reg;
    logic          out_last_reg;

    logic [NSW-1:0] lvl_ext;
    levels_t        lit_next;
    hold_t          d, d_next, deb_s;
    logic           pressed;
    logic           emit;
    logic           out_free;
    key_t           ev_key;
    logic [SW-1:0]  ev_shift;

    generate
        if (NSW > LINE_BITS) begin : g_lvl_wide
            assign lvl_ext  = {{(NSW-LINE_BITS){1'b1}}, levels_reg};
            assign lit_next = lat_next[LINE_BITS-1:0];
        end else if (NSW == LINE_BITS) begin : g_lvl_eq
            assign lvl_ext  = levels_reg;
            assign lit_next = lat_next;
        end else begin : g_lvl_narrow
            assign lvl_ext  = levels_reg[NSW-1:0];
            assign lit_next = {{(LINE_BITS-NSW){1'b0}}, lat_next};
        end
    endgenerate

    assign gk      = base_reg + IW'(k_reg);
    assign d       = rd_valid_reg ? rd_data_reg : '0;
    assign deb_s   = hold_t'({1'b0, deb_reg});
    assign pressed = ~lvl_ext[idx_reg];

    always_comb
    begin
        if (d > 8'sd1)
            d_next = d - 8'sd1;
        else if (d < 8'sd0)
            d_next = d + 8'sd1;
        else if (d == 8'sd0 && pressed)
            d_next = deb_s;
        else if (d == 8'sd1 && !pressed)
            d_next = -deb_s;
        else
            d_next = d;
    end

    always_comb
    begin
        lat_next = lat_reg;
        if (cmd.tog)
            lat_next[idx_reg] = ~lat_reg[idx_reg];
        else if (cmd.clr_k)
            lat_next[gk] = 1'b0;
    end

    assign emit     = cmd.tog | cmd.clr_k;
    assign out_free = ~out_valid_reg | ev.ready;
    assign ev_shift = cmd.tog ? s_reg : k_reg;
    assign ev_key   = (KEY_W'(g_reg) << KEY_STRIDE_SH) + KEY_BASE + KEY_W'(ev_shift);

    always_comb
    begin
        sts.press      = (d == 8'sd0) && pressed;
        sts.is_on      = lat_reg[idx_reg];
        sts.idx_last   = (idx_reg == IW'(NSW-1));
        sts.k_last     = (k_reg == SW'(SHIFTS-1));
        sts.k_hit      = (k_reg != s_reg) && lat_reg[gk];
        sts.can_emit   = ~pend_valid_reg | out_free;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg  <= DEB_RESET;
            chan_reg <= CHAN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE: deb_reg  <= cfg_data;
                CFG_CHANNEL:  chan_reg <= cfg_data[CHAN_W-1:0];
                default:      ;
            endcase
        end
    end

    // hold-off memory
    always_ff @(posedge clk)
    begin
        if (cmd.upd)
            mem[idx_reg] <= d_next;
        if (cmd.rd)
            rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg       <= '0;
            rd_valid_reg <= 1'b0;
            lat_reg      <= '0;
        end
        else
        begin
            if (cmd.upd)
                hv_reg[idx_reg] <= 1'b1;
            if (cmd.rd)
                rd_valid_reg <= hv_reg[idx_reg];
            lat_reg <= lat_next;
        end
    end

    // scan counters
    always_ff @(posedge clk)
    begin
        if (cmd.start)
            levels_reg <= levels;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            base_reg <= '0;
            g_reg    <= '0;
            s_reg    <= '0;
            k_reg    <= '0;
        end
        else if (cmd.start)
        begin
            idx_reg  <= '0;
            base_reg <= '0;
            g_reg    <= '0;
            s_reg    <= '0;
            k_reg    <= '0;
        end
        else
        begin
            if (cmd.adv)
            begin
                idx_reg <= idx_reg + IW'(1);
                if (s_reg == SW'(SHIFTS-1))
                begin
                    s_reg    <= '0;
                    g_reg    <= g_reg + GW'(1);
                    base_reg <= base_reg + IW'(SHIFTS);
                end
                else
                begin
                    s_reg <= s_reg + SW'(1);
                end
            end
            if (cmd.adv || cmd.tog)
                k_reg <= '0;
            else if (cmd.k_inc)
                k_reg <= k_reg + SW'(1);
        end
    end

    // pending event and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
                pend_valid_reg <= 1'b1;
            else if (cmd.flush)
                pend_valid_reg <= 1'b0;

            if ((emit && pend_valid_reg) || cmd.flush)
                out_valid_reg <= 1'b1;
            else if (ev.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pend_chan_reg <= chan_reg;
            pend_key_reg  <= ev_key;
            pend_on_reg   <= cmd.tog & ~lat_reg[idx_reg];
            pend_lit_reg  <= lit_next;
        end
        if ((emit && pend_valid_reg) || cmd.flush)
        begin
            out_chan_reg <= pend_chan_reg;
            out_key_reg  <= pend_key_reg;
            out_on_reg   <= pend_on_reg;
            out_lit_reg  <= pend_lit_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign ev.valid      = out_valid_reg;
    assign ev.channel    = out_chan_reg;
    assign ev.key_number = out_key_reg;
    assign ev.note_on    = out_on_reg;
    assign ev.lit_vector = out_lit_reg;
    assign ev.last_event = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/dtsg_ctrl.sv
// Controller: walks the switches of one scan tick and sequences events.
// Depends on dtsg_pkg.
`default_nettype none

module dtsg_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire dtsg_pkg::sts_t  sts,
    output dtsg_pkg::cmd_t       cmd
);
    import dtsg_pkg::*;

    state_t state_reg, state_next;
    logic   clr_step;

    assign clr_step = ~sts.k_hit | sts.can_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_READ;
            ST_READ:
                state_next = ST_EVAL;
            ST_EVAL:
                if (!sts.press)
                    state_next = sts.idx_last ? ST_FIN : ST_READ;
                else if (sts.can_emit)
                begin
                    if (!sts.is_on)
                        state_next = ST_CLR;
                    else
                        state_next = sts.idx_last ? ST_FIN : ST_READ;
                end
            ST_CLR:
                if (clr_step && sts.k_last)
                    state_next = sts.idx_last ? ST_FIN : ST_READ;
            ST_FIN:
                if (!sts.pend_valid || sts.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            ST_READ:
                cmd.rd = 1'b1;
            ST_EVAL:
                if (!sts.press)
                begin
                    cmd.upd = 1'b1;
                    cmd.adv = 1'b1;
                end
                else if (sts.can_emit)
                begin
                    cmd.upd = 1'b1;
                    cmd.tog = 1'b1;
                    cmd.adv = sts.is_on;
                end
            ST_CLR:
                if (clr_step)
                begin
                    cmd.clr_k = sts.k_hit;
                    cmd.adv   = sts.k_last;
                    cmd.k_inc = ~sts.k_last;
                end
            ST_FIN:
                cmd.flush = sts.pend_valid & sts.out_free;
            default:
                ;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/debounced_toggle_switch_groups_core.sv
// Top level of the debounced toggle switch groups block.
// Depends on dtsg_pkg, dtsg_in_if, dtsg_out_if, dtsg_ctrl and dtsg_dp.
//
//  channel   dir   beat
//  sw_in     in    raw active-low switch levels of one scan tick
//  ev_out    out   note event: channel, key, on/off, lit switches, last mark
//  cfg_*     in    register write: debounce ticks, note channel
//
// A scan tick visits each switch in two steps (hold-off memory read, then update),
// plus one step per shift of the group after each turn-on, plus one flush step.
// Stalls on ev_out can hold the steps that emit events, and the flush.
// The next tick is taken once the last event of a tick sits in the output register.
// Reset clears latches and hold-off counters at once and loads register defaults.
`default_nettype none

module debounced_toggle_switch_groups_core #(
    parameter int GROUPS = 3,
    parameter int SHIFTS = 3
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dtsg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dtsg_pkg::CFG_DAT_W-1:0] cfg_data,
    dtsg_in_if.sink                             sw_in,
    dtsg_out_if.source                          ev_out
);
    import dtsg_pkg::*;

    cmd_t cmd;
    sts_t sts;

    dtsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sw_in.valid),
        .in_ready (sw_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dtsg_dp #(
        .GROUPS (GROUPS),
        .SHIFTS (SHIFTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .levels    (sw_in.switch_levels),
        .cmd       (cmd),
        .sts       (sts),
        .ev        (ev_out)
    );

endmodule

`default_nettype wire

>>> tb/sv/debounced_toggle_switch_groups_core_tb.sv
// Self-checking testbench for debounced_toggle_switch_groups_core: scan ticks in,
// note events out, each event checked against a predictor of the switch groups.
// Depends on dtsg_pkg, dtsg_in_if, dtsg_out_if and the core itself.

module debounced_toggle_switch_groups_core_tb;

    import dtsg_pkg::*;

    localparam int GROUPS    = 3;
    localparam int SHIFTS    = 3;
    localparam int NSW       = GROUPS * SHIFTS;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE    = 100;

    typedef struct {
        chan_t   channel;
        key_t    key_number;
        logic    note_on;
        levels_t lit_vector;
        logic    last_event;
    } note_ev_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    dtsg_in_if  sw_if ();
    dtsg_out_if ev_if ();

    debounced_toggle_switch_groups_core #(
        .GROUPS (GROUPS),
        .SHIFTS (SHIFTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sw_in     (sw_if.sink),
        .ev_out    (ev_if.source)
    );

    // predictor state and configuration
    levels_t  lit_state = '0;
    int       holdoff[NSW];
    int       cur_debounce = DEB_RESET;
    chan_t    cur_channel  = CHAN_RESET;

    note_ev_t note_q[$];
    levels_t  level_q[$];
    int       pushed_cnt   = 0;
    int       accepted_cnt = 0;
    int       err_cnt      = 0;
    logic     in_beat      = 1'b0;

    int       burst_left = 0;
    int       gap_left   = 0;
    int       hold_left  = 0;
    int       mode_left  = 0;
    int       ready_pct  = 100;
    bit       hold_req   = 1'b0;
    bit       hold_done  = 1'b0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic push_note(input int g, input int s, input logic on);
        note_ev_t ev;
        ev.channel    = cur_channel;
        ev.key_number = key_t'(g * 8 + 3 + s);
        ev.note_on    = on;
        ev.lit_vector = lit_state;
        ev.last_event = 1'b0;
        note_q.push_back(ev);
    endtask

    task automatic predict_tick(input levels_t lv);
        int first;
        int idx;
        int d;
        bit pressed;
        first = note_q.size();
        for (int g = 0; g < GROUPS; g++)
        begin
            for (int s = 0; s < SHIFTS; s++)
            begin
                idx = g * SHIFTS + s;
                d   = holdoff[idx];
                if (d > 1)
                    holdoff[idx] = d - 1;
                else if (d < 0)
                    holdoff[idx] = d + 1;
                else
                begin
                    pressed = (idx < LINE_BITS) && !lv[idx];
                    if (pressed && d == 0)
                    begin
                        holdoff[idx] = cur_debounce;
                        if (lit_state[idx])
                        begin
                            lit_state[idx] = 1'b0;
                            push_note(g, s, 1'b0);
                        end
                        else
                        begin
                            lit_state[idx] = 1'b1;
                            push_note(g, s, 1'b1);
                            for (int k = 0; k < SHIFTS; k++)
                            begin
                                if (k != s && lit_state[g * SHIFTS + k])
                                begin
                                    lit_state[g * SHIFTS + k] = 1'b0;
                                    push_note(g, k, 1'b0);
                                end
                            end
                        end
                    end
                    else if (!pressed && d == 1)
                        holdoff[idx] = -cur_debounce;
                end
            end
        end
        if (note_q.size() > first)
            note_q[note_q.size() - 1].last_event = 1'b1;
    endtask

    // sample both channels, predict and check
    always @(posedge clk)
    begin : monitor
        note_ev_t want;
        if (rst_n)
        begin
            in_beat <= sw_if.valid && sw_if.ready;
            if (sw_if.valid && sw_if.ready)
            begin
                predict_tick(sw_if.switch_levels);
                accepted_cnt++;
            end
            if (ev_if.valid && ev_if.ready)
            begin
                if (note_q.size() == 0)
                begin
                    $error("unexpected event: key_number %0d note_on %0d",
                           ev_if.key_number, ev_if.note_on);
                    err_cnt++;
                end
                else
                begin
                    want = note_q.pop_front();
                    if (ev_if.channel !== want.channel)
                    begin
                        $error("channel: expected %0d, actual %0d", want.channel, ev_if.channel);
                        err_cnt++;
                    end
                    if (ev_if.key_number !== want.key_number)
                    begin
                        $error("key_number: expected %0d, actual %0d",
                               want.key_number, ev_if.key_number);
                        err_cnt++;
                    end
                    if (ev_if.note_on !== want.note_on)
                    begin
                        $error("note_on: expected %0d, actual %0d", want.note_on, ev_if.note_on);
                        err_cnt++;
                    end
                    if (ev_if.lit_vector !== want.lit_vector)
                    begin
                        $error("lit_vector: expected %h, actual %h",
                               want.lit_vector, ev_if.lit_vector);
                        err_cnt++;
                    end
                    if (ev_if.last_event !== want.last_event)
                    begin
                        $error("last_event: expected %0d, actual %0d",
                               want.last_event, ev_if.last_event);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // scan tick sender: bursts with random gaps
    always @(negedge clk)
    begin : driver
        logic    nxt_valid;
        levels_t nxt_lv;
        if (rst_n && (!sw_if.valid || in_beat))
        begin
            nxt_valid = 1'b0;
            nxt_lv    = sw_if.switch_levels;
            if (gap_left > 0)
                gap_left--;
            else if (level_q.size() > 0)
            begin
                nxt_valid = 1'b1;
                nxt_lv    = level_q.pop_front();
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            sw_if.valid         <= nxt_valid;
            sw_if.switch_levels <= nxt_lv;
        end
    end

    // event receiver: stall pattern of its own, one long hold-off on request
    always @(negedge clk)
    begin : receiver
        logic nxt_ready;
        if (rst_n)
        begin
            if (hold_req && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_ready = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(16, 80);
                    case ($urandom_range(0, 3))
                        0:       ready_pct = 100;
                        1:       ready_pct = 75;
                        2:       ready_pct = 40;
                        default: ready_pct = 15;
                    endcase
                end
                mode_left--;
                nxt_ready = ($urandom_range(0, 99) < ready_pct);
            end
            ev_if.ready <= nxt_ready;
        end
    end

    task automatic push_levels(input levels_t lv);
        level_q.push_back(lv);
        pushed_cnt++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DAT_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_DEBOUNCE)
            cur_debounce = value & 7'h7f;
        else
            cur_channel = chan_t'(value);
    endtask

    task automatic wait_idle();
        while (accepted_cnt != pushed_cnt || note_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // mostly press/hold/release sequences, some noise and short presses
    task automatic add_random(input int count);
        int      made;
        int      hold;
        int      rel;
        levels_t mask;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                push_levels(levels_t'($urandom_range(0, 511)));
                made++;
            end
            else
            begin
                mask = '0;
                if ($urandom_range(0, 4) == 0)
                    mask = levels_t'($urandom);
                else
                    repeat ($urandom_range(1, 3)) mask[$urandom_range(0, LINE_BITS - 1)] = 1'b1;
                hold = cur_debounce + $urandom_range(1, 2);
                rel  = cur_debounce + $urandom_range(1, 2);
                if ($urandom_range(0, 7) == 0)
                    hold = $urandom_range(1, cur_debounce + 1);
                if ($urandom_range(0, 7) == 0)
                    rel = $urandom_range(1, cur_debounce + 1);
                repeat (hold) push_levels(~mask);
                repeat (rel) push_levels('1);
                made += hold + rel;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < NSW; i++)
            holdoff[i] = 0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_DEBOUNCE;
        cfg_data            = '0;
        sw_if.valid         = 1'b0;
        sw_if.switch_levels = '1;
        ev_if.ready         = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults: nothing pressed, then one press
        push_levels(9'h1ff);
        push_levels(9'h1fe);
        wait_idle();

        write_reg(CFG_DEBOUNCE, 1);
        write_reg(CFG_CHANNEL, 15);
        push_levels(9'h1fd);
        push_levels(9'h1ff);
        push_levels(9'h1ff);
        push_levels(9'h000);
        push_levels(9'h1ff);
        push_levels(9'h1ff);
        push_levels(9'h000);
        push_levels(9'h000);
        push_levels(9'h1ff);
        push_levels(9'h1ff);
        push_levels(9'h0aa);
        push_levels(9'h1ff);
        push_levels(9'h1ff);
        push_levels(9'h155);
        wait_idle();

        // zero hold-off: a held press toggles every tick
        write_reg(CFG_DEBOUNCE, 0);
        write_reg(CFG_CHANNEL, 7);
        push_levels(9'h1ef);
        push_levels(9'h1ef);
        push_levels(9'h1ef);
        push_levels(9'h1ff);
        push_levels(9'h000);
        push_levels(9'h000);
        wait_idle();

        write_reg(CFG_DEBOUNCE, 1);
        write_reg(CFG_CHANNEL, $urandom_range(0, 15));
        hold_req = 1'b1;
        add_random(90);
        wait_idle();

        write_reg(CFG_DEBOUNCE, 2);
        write_reg(CFG_CHANNEL, $urandom_range(0, 15));
        add_random(90);
        wait_idle();

        write_reg(CFG_DEBOUNCE, 3);
        write_reg(CFG_CHANNEL, 15);
        add_random(90);
        wait_idle();

        write_reg(CFG_DEBOUNCE, 5);
        write_reg(CFG_CHANNEL, 0);
        add_random(80);
        wait_idle();

        // longest hold-off: one press of everything, then noise inside the hold-off
        write_reg(CFG_DEBOUNCE, 127);
        write_reg(CFG_CHANNEL, $urandom_range(0, 15));
        push_levels(9'h000);
        repeat (20) push_levels(levels_t'($urandom_range(0, 511)));
        wait_idle();

        if (err_cnt == 0)
            $display("debounced_toggle_switch_groups_core test passed");
        else
            $display("debounced_toggle_switch_groups_core test failed");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("debounced_toggle_switch_groups_core test failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/dtsg_pkg.sv
rtl/dtsg_in_if.sv
rtl/dtsg_out_if.sv
rtl/dtsg_dp.sv
rtl/dtsg_ctrl.sv
rtl/debounced_toggle_switch_groups_core.sv
tb/sv/debounced_toggle_switch_groups_core_tb.sv
